>>> rtl/arp_responder_with_cache_macros.svh
// Assertion macros shared by the ARP responder RTL.
// Uses the clk and arst_n names of the including module.
`ifndef ARP_RESPONDER_WITH_CACHE_MACROS_SVH
`define ARP_RESPONDER_WITH_CACHE_MACROS_SVH
`ifndef SYNTHESIS
`define ARPC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("arpc assertion failed");
`define ARPC_ASSERT_NORST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("arpc assertion failed");
`else
`define ARPC_ASSERT(lbl, prop)
`define ARPC_ASSERT_NORST(lbl, prop)
`endif
`endif

>>> rtl/arpc_pkg.sv
// Types and constants of the ARP responder with address cache.
// No dependencies.
`default_nettype none
package arpc_pkg;

	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'h0001;
	localparam logic [15:0] OP_REPLY    = 16'h0002;

	localparam logic [1:0] KIND_FRAME  = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_SEND   = 2'd2;

	localparam logic [1:0] FOP_NONE    = 2'd0;
	localparam logic [1:0] FOP_REQUEST = 2'd1;
	localparam logic [1:0] FOP_REPLY   = 2'd2;

	localparam logic [2:0] ACT_DROPPED    = 3'd0;
	localparam logic [2:0] ACT_REPLIED    = 3'd1;
	localparam logic [2:0] ACT_NOT_OURS   = 3'd2;
	localparam logic [2:0] ACT_LEARNED    = 3'd3;
	localparam logic [2:0] ACT_NOT_STORED = 3'd4;
	localparam logic [2:0] ACT_HIT        = 3'd5;
	localparam logic [2:0] ACT_MISS       = 3'd6;
	localparam logic [2:0] ACT_REQ_SENT   = 3'd7;

	localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
	localparam logic [1:0] REG_LOCAL_MAC   = 2'd1;
	localparam logic [1:0] REG_GATEWAY_IP  = 2'd2;
	localparam logic [1:0] REG_SUBNET_MASK = 2'd3;

	localparam logic [47:0] MAC_ONES     = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] IP_ONES      = 32'hFFFF_FFFF;
	localparam logic [31:0] SUBNET_RESET = 32'hFFFF_FF00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SEARCH,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] key;
	} srch_req_t;

	typedef struct packed {
		logic        done;
		logic        hit;
		logic [47:0] mac;
	} srch_rsp_t;

endpackage
`default_nettype wire

>>> rtl/arp_responder_with_cache.sv
// ARP responder with IPv4-to-Ethernet address cache, top level.
// Depends on arpc_pkg, arpc_search and the assertion macro header.
//
// Requests enter on s_tvalid/s_tready: s_tuser carries the kind (received
// ARP frame, cache lookup, emit request), s_tdata the frame fields. Each
// request yields one result on m_tvalid/m_tready: m_tuser carries the action
// code, m_tdata the outgoing frame fields and the found MAC.
// Configuration goes through cfg_we/cfg_addr/cfg_wdata, to be written while
// idle by the user; the block does not enforce this. One request is in
// flight at a time; s_tready is high only when idle. A request needing no
// table access passes from acceptance through the decode and push states to
// the result register. A lookup or a learned reply walks the table through
// the single compare unit, one entry per cycle, comparing at most the fill
// count of entries (2 to CACHE_ENTRIES); a learn with the table full skips
// the search. The next request is taken from idle, after the result loads.
// Reset clears the table to its broadcast and zero-address entries, sets the
// registers to their defaults and empties the output register at once.
// A stalled result is held in the output register; the next request is taken
// and worked out, then held until that result is taken.
`default_nettype none
`include "arp_responder_with_cache_macros.svh"
module arp_responder_with_cache import arpc_pkg::*; #(
	parameter int CACHE_ENTRIES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// hw_type[15:0] proto_type[31:16] opcode[47:32] sender_mac[95:48]
	// sender_ip[127:96] target_ip[159:128]
	input  wire logic [159:0] s_tdata,
	// kind[1:0]
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// send_frame[0] frame_op[2:1] frame_dest_mac[50:3] frame_target_mac[98:51]
	// frame_target_ip[130:99] found_mac[178:131], zero pad [183:179]
	output logic [183:0]      m_tdata,
	// action[2:0]
	output logic [2:0]        m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_addr,
	input  wire logic [47:0]  cfg_wdata
);

	localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CW = $clog2(CACHE_ENTRIES + 1);

	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;
	logic [31:0] gateway_ip_q;
	logic [31:0] subnet_mask_q;

	state_t state_q, state_d;

	logic [1:0]  kind_q;
	logic [15:0] hard_q, proto_q, op_q;
	logic [47:0] smac_q;
	logic [31:0] sip_q, tip_q;

	logic [CW-1:0] count_q;

	logic [2:0]  act_q;
	logic        send_q;
	logic [1:0]  fop_q;
	logic [47:0] dmac_q, tmac_q, found_q;
	logic [31:0] ftip_q;

	logic          m_tvalid_q;
	logic [183:0]  m_tdata_q;
	logic [2:0]    m_tuser_q;

	srch_req_t req;
	srch_rsp_t rsp;

	logic        types_ok;
	logic        room;
	logic        off_sub;
	logic [31:0] res_ip;
	logic        need_search;
	logic        wr_en;
	logic        load_out;

	assign types_ok = (hard_q == HW_ETHERNET) && (proto_q == PROTO_IPV4);
	assign room     = count_q < CW'(CACHE_ENTRIES);
	assign off_sub  = (tip_q & subnet_mask_q) != (local_ip_q & subnet_mask_q);
	assign res_ip   = off_sub ? gateway_ip_q : tip_q;
	assign need_search = (kind_q == KIND_LOOKUP) ||
		((kind_q == KIND_FRAME) && types_ok && (op_q == OP_REPLY) && room);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = need_search ? ST_SEARCH : ST_PUSH;
			end
			ST_SEARCH: begin
				if (rsp.done) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		req.start = (state_q == ST_DECODE) && need_search;
		req.key   = (kind_q == KIND_LOOKUP) ? res_ip : sip_q;
		wr_en     = (state_q == ST_SEARCH) && rsp.done && !rsp.hit &&
			(kind_q == KIND_FRAME);
		load_out  = (state_q == ST_PUSH) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			local_ip_q    <= '0;
			local_mac_q   <= '0;
			gateway_ip_q  <= '0;
			subnet_mask_q <= SUBNET_RESET;
			count_q       <= CW'(2);
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_LOCAL_IP:    local_ip_q    <= cfg_wdata[31:0];
					REG_LOCAL_MAC:   local_mac_q   <= cfg_wdata;
					REG_GATEWAY_IP:  gateway_ip_q  <= cfg_wdata[31:0];
					REG_SUBNET_MASK: subnet_mask_q <= cfg_wdata[31:0];
					default: ;
				endcase
			end
			if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q  <= s_tuser;
			hard_q  <= s_tdata[15:0];
			proto_q <= s_tdata[31:16];
			op_q    <= s_tdata[47:32];
			smac_q  <= s_tdata[95:48];
			sip_q   <= s_tdata[127:96];
			tip_q   <= s_tdata[159:128];
		end
		if (state_q == ST_DECODE) begin
			act_q   <= ACT_DROPPED;
			send_q  <= 1'b0;
			fop_q   <= FOP_NONE;
			dmac_q  <= '0;
			tmac_q  <= '0;
			ftip_q  <= '0;
			found_q <= '0;
			case (kind_q)
				KIND_FRAME: begin
					if (types_ok && (op_q == OP_REQUEST)) begin
						if (tip_q == local_ip_q) begin
							act_q  <= ACT_REPLIED;
							send_q <= 1'b1;
							fop_q  <= FOP_REPLY;
							dmac_q <= smac_q;
							tmac_q <= smac_q;
							ftip_q <= sip_q;
						end else begin
							act_q <= ACT_NOT_OURS;
						end
					end else if (types_ok && (op_q == OP_REPLY)) begin
						act_q <= ACT_NOT_STORED;
					end
				end
				KIND_SEND: begin
					act_q  <= ACT_REQ_SENT;
					send_q <= 1'b1;
					fop_q  <= FOP_REQUEST;
					dmac_q <= MAC_ONES;
					ftip_q <= res_ip;
				end
				default: ;
			endcase
		end else if ((state_q == ST_SEARCH) && rsp.done) begin
			if (kind_q == KIND_LOOKUP) begin
				act_q   <= rsp.hit ? ACT_HIT : ACT_MISS;
				found_q <= rsp.hit ? rsp.mac : '0;
			end else begin
				act_q <= rsp.hit ? ACT_NOT_STORED : ACT_LEARNED;
			end
		end
		if (load_out) begin
			m_tuser_q <= act_q;
			m_tdata_q <= {5'b0, found_q, ftip_q, tmac_q, dmac_q, fop_q, send_q};
		end
	end

	arpc_search #(
		.CACHE_ENTRIES(CACHE_ENTRIES),
		.IW(IW),
		.CW(CW)
	) u_search (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.count(count_q),
		.wr_en(wr_en),
		.wr_addr(count_q[IW-1:0]),
		.wr_ip(sip_q),
		.wr_mac(smac_q)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`ARPC_ASSERT(a_count_range, (count_q >= CW'(2)) && (count_q <= CW'(CACHE_ENTRIES)))
	`ARPC_ASSERT(a_accept_decode, (s_tvalid && s_tready) |=> (state_q == ST_DECODE))
	`ARPC_ASSERT(a_learn_count, wr_en |=> (count_q == $past(count_q) + CW'(1)))

endmodule
`default_nettype wire

>>> rtl/arpc_search.sv
// Address table storage and sequential compare unit, one entry per cycle.
// Depends on arpc_pkg and the assertion macro header.
`default_nettype none
`include "arp_responder_with_cache_macros.svh"
module arpc_search import arpc_pkg::*; #(
	parameter int CACHE_ENTRIES = 16,
	parameter int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1,
	parameter int CW = $clog2(CACHE_ENTRIES + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire srch_req_t       req,
	output srch_rsp_t            rsp,
	input  wire logic [CW-1:0]   count,
	input  wire logic            wr_en,
	input  wire logic [IW-1:0]   wr_addr,
	input  wire logic [31:0]     wr_ip,
	input  wire logic [47:0]     wr_mac
);

	logic [31:0] ip_mem  [CACHE_ENTRIES];
	logic [47:0] mac_mem [CACHE_ENTRIES];

	logic          busy_q;
	logic [CW-1:0] rd_idx_q;
	logic [31:0]   key_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [31:0]   ip_s1;
	logic [47:0]   mac_s1;
	logic          done_q;
	logic          hit_q;
	logic [47:0]   mac_q;

	logic          issue;
	logic [31:0]   entry_ip;
	logic [47:0]   entry_mac;
	logic          cmp_vld;
	logic          match;
	logic          last;

	assign issue   = busy_q && (rd_idx_q < count);
	assign cmp_vld = busy_q && rd_vld_s1;

	always_comb begin
		if (rd_idx_s1 == IW'(0)) begin
			entry_ip  = IP_ONES;
			entry_mac = MAC_ONES;
		end else if (rd_idx_s1 == IW'(1)) begin
			entry_ip  = '0;
			entry_mac = MAC_ONES;
		end else begin
			entry_ip  = ip_s1;
			entry_mac = mac_s1;
		end
	end

	assign match = cmp_vld && (entry_ip == key_q);
	assign last  = cmp_vld && (CW'(rd_idx_s1) == count - CW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ip_mem[wr_addr]  <= wr_ip;
			mac_mem[wr_addr] <= wr_mac;
		end
		ip_s1  <= ip_mem[rd_idx_q[IW-1:0]];
		mac_s1 <= mac_mem[rd_idx_q[IW-1:0]];
		rd_idx_s1 <= rd_idx_q[IW-1:0];
		if (match) begin
			mac_q <= entry_mac;
		end
		if (req.start) begin
			key_q <= req.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q    <= 1'b1;
				rd_idx_q  <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (match || last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					hit_q  <= match;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.hit  = hit_q;
	assign rsp.mac  = mac_q;

	`ARPC_ASSERT(a_no_write_busy, wr_en |-> !busy_q)
	`ARPC_ASSERT(a_start_idle, req.start |-> !busy_q)
	`ARPC_ASSERT(a_cmp_in_range, cmp_vld |-> (CW'(rd_idx_s1) < count))
	`ARPC_ASSERT(a_done_after_cmp, done_q |-> $past(cmp_vld))

endmodule
`default_nettype wire
